// ----- design/rmv_pkg.sv -----
// Shared types and constants for the running mean / variance core.
// No dependencies; compile first.
`timescale 1ns / 1ps
`default_nettype none

package rmv_pkg;

   localparam int SAMPLE_W    = 16;
   localparam int COUNT_OUT_W = 24;
   localparam int MEAN_W      = 32;
   localparam int M2_W        = 64;
   localparam int VAR_W       = 48;
   localparam int STATUS_W    = 2;

   localparam logic signed [MEAN_W-1:0] MEAN_MAX_C = 32'sh7fff_ffff;
   localparam logic signed [MEAN_W-1:0] MEAN_MIN_C = 32'sh8000_0000;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK        = 2'd0,
      STAT_SINGLE    = 2'd1,
      STAT_SATURATED = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_PREP,
      S_DIVM,
      S_MEAN,
      S_D2,
      S_MUL_LO,
      S_MUL_HI,
      S_SUM,
      S_COMMIT,
      S_VAR_INIT,
      S_DIVV,
      S_OUT
   } state_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_MARK_SAT,
      OP_DIVM_INIT,
      OP_DIV_STEP,
      OP_MEAN,
      OP_D2,
      OP_MUL_LO,
      OP_MUL_HI,
      OP_SUM,
      OP_COMMIT,
      OP_DIVV_INIT,
      OP_OUT
   } dp_op_type;

   typedef struct packed {
      logic at_limit;     // count register holds its maximum
      logic few_samples;  // fewer than two samples, variance is zero
   } dp_stat_type;

   // magnitude width of x - mean for a given number of fraction bits
   function automatic int mag_width(input int frac);
      return (SAMPLE_W + frac > MEAN_W) ? SAMPLE_W + frac : MEAN_W;
   endfunction

endpackage

`default_nettype wire

// ----- design/rmv_if.sv -----
// Request and response channel interfaces of the running mean / variance core.
// Depends on rmv_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface rmv_req_if;
   import rmv_pkg::*;
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] sample;
   logic                       restart;

   modport source (output valid, output sample, output restart, input ready);
   modport sink   (input valid, input sample, input restart, output ready);
endinterface

interface rmv_rsp_if;
   import rmv_pkg::*;
   logic                       valid;
   logic                       ready;
   logic [COUNT_OUT_W-1:0]     sample_count;
   logic signed [MEAN_W-1:0]   mean_value;
   logic [M2_W-1:0]            sum_sq_dev;
   logic [VAR_W-1:0]           variance_out;
   logic [STATUS_W-1:0]        status;

   modport source (output valid, output sample_count, output mean_value,
                   output sum_sq_dev, output variance_out, output status,
                   input ready);
   modport sink   (input valid, input sample_count, input mean_value,
                   input sum_sq_dev, input variance_out, input status,
                   output ready);
endinterface

`default_nettype wire

// ----- design/running_mean_variance_core.sv -----
// Top level of the running mean / variance core (Welford update, fixed point).
// Depends on rmv_pkg, rmv_req_if / rmv_rsp_if, rmv_controller, rmv_datapath.
//
//   channel  | direction | payload
//   ---------+-----------+---------------------------------------------------
//   req_ch   | in        | sample (s16), restart
//   rsp_ch   | out       | sample_count, mean_value, sum_sq_dev,
//            |           | variance_out, status
//
// Sequencing: one item at a time. The two serial divisions run one quotient
// bit a cycle in the shared restoring divider. With fewer than two samples
// the variance division is skipped; a saturated count skips the mean update.
// Reset: synchronous, clears count, mean and M2 and drops any pending item.
// Stalls: the result register lets the core take the next item while the
// last result still waits; a finished item holds until that register drains.
`timescale 1ns / 1ps
`default_nettype none

module running_mean_variance_core #(
   parameter int COUNT_BITS = 24,
   parameter int FRAC_BITS  = 16
) (
   input  wire logic   clock,
   input  wire logic   reset,
   rmv_req_if.sink     req_ch,
   rmv_rsp_if.source   rsp_ch
);
   import rmv_pkg::*;

   dp_op_type    dp_op;    // per-cycle datapath command
   dp_stat_type  dp_stat;  // count limits, back to the controller

   // sequence control and handshake flags
   rmv_controller #(
      .FRAC_BITS (FRAC_BITS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .dp_op     (dp_op),
      .dp_stat   (dp_stat)
   );

   // statistics state, divider, multiplier and result register
   rmv_datapath #(
      .COUNT_BITS (COUNT_BITS),
      .FRAC_BITS  (FRAC_BITS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .dp_op            (dp_op),
      .dp_stat          (dp_stat),
      .req_sample       (req_ch.sample),
      .req_restart      (req_ch.restart),
      .rsp_sample_count (rsp_ch.sample_count),
      .rsp_mean_value   (rsp_ch.mean_value),
      .rsp_sum_sq_dev   (rsp_ch.sum_sq_dev),
      .rsp_variance_out (rsp_ch.variance_out),
      .rsp_status       (rsp_ch.status)
   );

`ifndef NO_ASSERTIONS
   // no new item is taken while one is in the datapath
   a_busy_blocks_req: assert property (@(posedge clock) disable iff (reset)
      (dp_op != OP_NONE && dp_op != OP_LOAD) |-> !req_ch.ready)
      else $error("item accepted while datapath busy");

   // the result register is only overwritten when it is free
   a_out_slot_free: assert property (@(posedge clock) disable iff (reset)
      (dp_op == OP_OUT) |-> (!rsp_ch.valid || rsp_ch.ready))
      else $error("pending result overwritten");

   // a loaded result is offered in the next cycle
   a_out_shown: assert property (@(posedge clock) disable iff (reset)
      (dp_op == OP_OUT) |=> rsp_ch.valid)
      else $error("loaded result not presented");

   // a single-sample result carries zero variance
   a_single_zero_var: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.status == STAT_SINGLE) |-> (rsp_ch.variance_out == '0))
      else $error("single-sample result with nonzero variance");
`endif

endmodule

`default_nettype wire

// ----- design/rmv_datapath.sv -----
// Datapath: statistics registers, shared serial divider, split multiplier,
// result register. Driven by rmv_controller; depends on rmv_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rmv_datapath #(
   parameter int COUNT_BITS = 24,
   parameter int FRAC_BITS  = 16
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire rmv_pkg::dp_op_type                   dp_op,
   output rmv_pkg::dp_stat_type                      dp_stat,
   input  wire logic signed [rmv_pkg::SAMPLE_W-1:0]  req_sample,
   input  wire logic                                 req_restart,
   output logic [rmv_pkg::COUNT_OUT_W-1:0]           rsp_sample_count,
   output logic signed [rmv_pkg::MEAN_W-1:0]         rsp_mean_value,
   output logic [rmv_pkg::M2_W-1:0]                  rsp_sum_sq_dev,
   output logic [rmv_pkg::VAR_W-1:0]                 rsp_variance_out,
   output logic [rmv_pkg::STATUS_W-1:0]              rsp_status
);
   import rmv_pkg::*;

   localparam int MW     = mag_width(FRAC_BITS);
   localparam int XQ_W   = SAMPLE_W + FRAC_BITS;
   localparam int DW     = MW + 1;
   localparam int MN_W   = MW + 2;
   localparam int HW     = (MW + 1) / 2;
   localparam int PP_W   = MW + HW;
   localparam int INC_HI = M2_W + FRAC_BITS;
   localparam int EXT_W  = ((2 * MW > INC_HI) ? 2 * MW : INC_HI) + 1;
   localparam int CE_W   = COUNT_BITS + COUNT_OUT_W;

   localparam logic signed [MN_W-1:0] MN_MAX = MEAN_MAX_C;
   localparam logic signed [MN_W-1:0] MN_MIN = MEAN_MIN_C;

   logic [COUNT_BITS-1:0]      count_ff, count_in;
   logic signed [MEAN_W-1:0]   mean_ff, mean_in;
   logic [M2_W-1:0]            m2_ff, m2_in;
   logic signed [XQ_W-1:0]     xq_ff, xq_in;
   logic                       neg_ff, neg_in;
   logic [MW-1:0]              d1mag_ff, d1mag_in;
   logic signed [MEAN_W-1:0]   mn_ff, mn_in;
   logic [MW-1:0]              d2mag_ff, d2mag_in;
   logic [M2_W-1:0]            dq_ff, dq_in;
   logic [COUNT_BITS-1:0]      drem_ff, drem_in;
   logic [COUNT_BITS-1:0]      ddiv_ff, ddiv_in;
   logic [PP_W-1:0]            plo_ff, plo_in;
   logic [PP_W-1:0]            phi_ff, phi_in;
   logic [M2_W-1:0]            inc_ff, inc_in;
   status_type                 stat_ff, stat_in;

   logic [COUNT_OUT_W-1:0]     cnt_out_ff, cnt_out_in;
   logic signed [MEAN_W-1:0]   mean_out_ff, mean_out_in;
   logic [M2_W-1:0]            m2_out_ff, m2_out_in;
   logic [VAR_W-1:0]           var_out_ff, var_out_in;
   logic [STATUS_W-1:0]        stat_out_ff, stat_out_in;

   logic signed [DW-1:0]       d1, d2;
   logic [MW-1:0]              d1mag, d2mag;
   logic signed [MN_W-1:0]     mn_wide;
   logic signed [MEAN_W-1:0]   mn_sat;
   logic [HW-1:0]              mul_b;
   logic [PP_W-1:0]            mul_p;
   logic [EXT_W-1:0]           prod_ext;
   logic [M2_W-1:0]            inc_sat;
   logic [M2_W:0]              m2_sum;
   logic [COUNT_BITS:0]        trial, trial_diff;
   logic                       trial_ge;
   logic [CE_W-1:0]            cnt_wide;
   logic                       few;

   always_comb begin
      few = count_ff < COUNT_BITS'(2);
      dp_stat.at_limit    = &count_ff;
      dp_stat.few_samples = few;

      // delta1 and delta2 in sign-magnitude form
      d1    = DW'(xq_ff) - DW'(mean_ff);
      d1mag = d1[DW-1] ? MW'(-d1) : MW'(d1);
      d2    = DW'(xq_ff) - DW'(mn_ff);
      d2mag = d2[DW-1] ? MW'(-d2) : MW'(d2);

      // mean update, clamped to the mean register range
      if (neg_ff) begin
         mn_wide = MN_W'(mean_ff) - $signed({2'b00, dq_ff[MW-1:0]});
      end else begin
         mn_wide = MN_W'(mean_ff) + $signed({2'b00, dq_ff[MW-1:0]});
      end
      if (mn_wide > MN_MAX) begin
         mn_sat = MEAN_MAX_C;
      end else if (mn_wide < MN_MIN) begin
         mn_sat = MEAN_MIN_C;
      end else begin
         mn_sat = mn_wide[MEAN_W-1:0];
      end

      // one multiplier, used for the low and then the high half of delta2
      if (dp_op == OP_MUL_HI) begin
         mul_b = HW'(d2mag_ff[MW-1:HW]);
      end else begin
         mul_b = d2mag_ff[HW-1:0];
      end
      mul_p = PP_W'(d1mag_ff) * PP_W'(mul_b);

      prod_ext = EXT_W'(plo_ff) + (EXT_W'(phi_ff) << HW);
      if (|prod_ext[EXT_W-1:INC_HI]) begin
         inc_sat = '1;
      end else begin
         inc_sat = prod_ext[INC_HI-1:FRAC_BITS];
      end
      m2_sum = {1'b0, m2_ff} + {1'b0, inc_ff};

      // restoring divider step
      trial      = {drem_ff, dq_ff[M2_W-1]};
      trial_ge   = trial >= {1'b0, ddiv_ff};
      trial_diff = trial - {1'b0, ddiv_ff};

      cnt_wide = CE_W'(count_ff);
   end

   always_comb begin
      count_in    = count_ff;
      mean_in     = mean_ff;
      m2_in       = m2_ff;
      xq_in       = xq_ff;
      neg_in      = neg_ff;
      d1mag_in    = d1mag_ff;
      mn_in       = mn_ff;
      d2mag_in    = d2mag_ff;
      dq_in       = dq_ff;
      drem_in     = drem_ff;
      ddiv_in     = ddiv_ff;
      plo_in      = plo_ff;
      phi_in      = phi_ff;
      inc_in      = inc_ff;
      stat_in     = stat_ff;
      cnt_out_in  = cnt_out_ff;
      mean_out_in = mean_out_ff;
      m2_out_in   = m2_out_ff;
      var_out_in  = var_out_ff;
      stat_out_in = stat_out_ff;
      case (dp_op)
         OP_LOAD: begin
            xq_in = {req_sample, {FRAC_BITS{1'b0}}};
            if (req_restart) begin
               count_in = '0;
               mean_in  = '0;
               m2_in    = '0;
            end
         end
         OP_MARK_SAT: begin
            stat_in = STAT_SATURATED;
         end
         OP_DIVM_INIT: begin
            neg_in   = d1[DW-1];
            d1mag_in = d1mag;
            dq_in    = {d1mag, {(M2_W - MW){1'b0}}};
            drem_in  = '0;
            ddiv_in  = count_ff + COUNT_BITS'(1);
            stat_in  = (count_ff == '0) ? STAT_SINGLE : STAT_OK;
         end
         OP_DIV_STEP: begin
            dq_in   = {dq_ff[M2_W-2:0], trial_ge};
            drem_in = trial_ge ? trial_diff[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
         end
         OP_MEAN:   mn_in    = mn_sat;
         OP_D2:     d2mag_in = d2mag;
         OP_MUL_LO: plo_in   = mul_p;
         OP_MUL_HI: phi_in   = mul_p;
         OP_SUM:    inc_in   = inc_sat;
         OP_COMMIT: begin
            count_in = count_ff + COUNT_BITS'(1);
            mean_in  = mn_ff;
            m2_in    = m2_sum[M2_W] ? '1 : m2_sum[M2_W-1:0];
         end
         OP_DIVV_INIT: begin
            dq_in   = m2_ff;
            drem_in = '0;
            ddiv_in = count_ff - COUNT_BITS'(1);
         end
         OP_OUT: begin
            cnt_out_in  = cnt_wide[COUNT_OUT_W-1:0];
            mean_out_in = mean_ff;
            m2_out_in   = m2_ff;
            if (few) begin
               var_out_in = '0;
            end else if (|dq_ff[M2_W-1:VAR_W]) begin
               var_out_in = '1;
            end else begin
               var_out_in = dq_ff[VAR_W-1:0];
            end
            stat_out_in = stat_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         mean_ff  <= '0;
         m2_ff    <= '0;
      end else begin
         count_ff <= count_in;
         mean_ff  <= mean_in;
         m2_ff    <= m2_in;
      end
   end

   always_ff @(posedge clock) begin
      xq_ff       <= xq_in;
      neg_ff      <= neg_in;
      d1mag_ff    <= d1mag_in;
      mn_ff       <= mn_in;
      d2mag_ff    <= d2mag_in;
      dq_ff       <= dq_in;
      drem_ff     <= drem_in;
      ddiv_ff     <= ddiv_in;
      plo_ff      <= plo_in;
      phi_ff      <= phi_in;
      inc_ff      <= inc_in;
      stat_ff     <= stat_in;
      cnt_out_ff  <= cnt_out_in;
      mean_out_ff <= mean_out_in;
      m2_out_ff   <= m2_out_in;
      var_out_ff  <= var_out_in;
      stat_out_ff <= stat_out_in;
   end

   assign rsp_sample_count = cnt_out_ff;
   assign rsp_mean_value   = mean_out_ff;
   assign rsp_sum_sq_dev   = m2_out_ff;
   assign rsp_variance_out = var_out_ff;
   assign rsp_status       = stat_out_ff;

endmodule

`default_nettype wire

// ----- design/rmv_controller.sv -----
// Controller: sequences one item through the datapath and owns the
// handshake flags. Depends on rmv_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rmv_controller #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output rmv_pkg::dp_op_type         dp_op,
   input  wire rmv_pkg::dp_stat_type  dp_stat
);
   import rmv_pkg::*;

   localparam int MW    = mag_width(FRAC_BITS);
   localparam int CNT_W = $clog2(M2_W);

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   step_ff, step_in;
   logic               rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      dp_op    = OP_NONE;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               dp_op    = OP_LOAD;
               state_in = S_PREP;
            end
         end
         S_PREP: begin
            if (dp_stat.at_limit) begin
               dp_op    = OP_MARK_SAT;
               state_in = S_VAR_INIT;
            end else begin
               dp_op    = OP_DIVM_INIT;
               step_in  = CNT_W'(MW - 1);
               state_in = S_DIVM;
            end
         end
         S_DIVM: begin
            dp_op   = OP_DIV_STEP;
            step_in = step_ff - CNT_W'(1);
            if (step_ff == '0) begin
               state_in = S_MEAN;
            end
         end
         S_MEAN: begin
            dp_op    = OP_MEAN;
            state_in = S_D2;
         end
         S_D2: begin
            dp_op    = OP_D2;
            state_in = S_MUL_LO;
         end
         S_MUL_LO: begin
            dp_op    = OP_MUL_LO;
            state_in = S_MUL_HI;
         end
         S_MUL_HI: begin
            dp_op    = OP_MUL_HI;
            state_in = S_SUM;
         end
         S_SUM: begin
            dp_op    = OP_SUM;
            state_in = S_COMMIT;
         end
         S_COMMIT: begin
            dp_op    = OP_COMMIT;
            state_in = S_VAR_INIT;
         end
         S_VAR_INIT: begin
            if (dp_stat.few_samples) begin
               state_in = S_OUT;
            end else begin
               dp_op    = OP_DIVV_INIT;
               step_in  = CNT_W'(M2_W - 1);
               state_in = S_DIVV;
            end
         end
         S_DIVV: begin
            dp_op   = OP_DIV_STEP;
            step_in = step_ff - CNT_W'(1);
            if (step_ff == '0) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               dp_op    = OP_OUT;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      rsp_valid_in = (dp_op == OP_OUT) || (rsp_valid_ff && !rsp_ready);
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

// ----- test/tb.sv -----
// Self-checking bench for running_mean_variance_core: Welford mean/M2/variance
// per sample, checked against an in-bench fixed-point tracker.
// Depends on rmv_pkg, rmv_if.sv and the core RTL.
`timescale 1ns / 1ps

module tb;
   import rmv_pkg::*;

   // Count and fraction widths stay at the core's defaults.
   localparam int CNT_BITS     = 24;
   localparam int FRAC         = 16;
   localparam int COUNT_LIMIT  = (1 << CNT_BITS) - 1;
   localparam int RANDOM_ITEMS = 600;
   localparam int LONG_RUN     = 262;   // one long run, led by a restart
   localparam int LONG_HOLD    = 600;   // receiver hold-off, in cycles
   localparam int PRESSURE_AT  = 60;    // random item index that starts it
   localparam int DRAIN_CYCLES = 200;   // above the slowest item latency

   typedef struct packed {
      logic [COUNT_OUT_W-1:0]   sample_count;
      logic signed [MEAN_W-1:0] mean_value;
      logic [M2_W-1:0]          sum_sq_dev;
      logic [VAR_W-1:0]         variance_out;
      logic [STATUS_W-1:0]      status;
   } stats_item_type;

   // Tracks count, mean and M2 the way the core does and keeps the stats
   // every accepted sample must produce, oldest first.
   class welford_tracker_type;
      bit [31:0]               cnt;
      bit signed [MEAN_W-1:0]  mean;
      bit [M2_W-1:0]           m2;
      stats_item_type          expected_stats[$];
      int                      errors;

      function new();
         cnt    = 0;
         mean   = 0;
         m2     = 0;
         errors = 0;
      endfunction

      // Fold one accepted sample into the running stats and queue the result.
      function void fold_sample(logic signed [SAMPLE_W-1:0] x, logic rst);
         longint         xq, m, n, d1, d2, q, mn;
         bit [63:0]      ad1, ad2, inc, divisor, vq;
         bit [127:0]     prod;
         bit [64:0]      acc;
         stats_item_type want;
         if (rst) begin
            cnt  = 0;
            mean = 0;
            m2   = 0;
         end
         if (cnt >= COUNT_LIMIT) begin
            // full count: drop the sample, report the state as it stands
            want.status = STAT_SATURATED;
         end else begin
            xq = longint'(x) <<< FRAC;
            m  = longint'(mean);
            n  = longint'(cnt) + 1;
            d1 = xq - m;
            ad1 = (d1 < 0) ? -d1 : d1;
            q  = longint'(ad1) / n;
            mn = (d1 < 0) ? m - q : m + q;
            if (mn > longint'(MEAN_MAX_C)) mn = longint'(MEAN_MAX_C);
            if (mn < longint'(MEAN_MIN_C)) mn = longint'(MEAN_MIN_C);
            d2 = xq - mn;
            ad2 = (d2 < 0) ? -d2 : d2;
            prod = {64'd0, ad1} * {64'd0, ad2};
            if (prod[127:64+FRAC] != 0) inc = '1;
            else inc = prod[64+FRAC-1:FRAC];
            acc  = {1'b0, m2} + {1'b0, inc};
            m2   = acc[64] ? '1 : acc[63:0];
            cnt  = n[31:0];
            mean = mn[MEAN_W-1:0];
            want.status = (n == 1) ? STAT_SINGLE : STAT_OK;
         end
         want.sample_count = cnt[COUNT_OUT_W-1:0];
         want.mean_value   = mean;
         want.sum_sq_dev   = m2;
         if (cnt < 2) begin
            want.variance_out = '0;
         end else begin
            divisor = 64'(cnt) - 64'd1;
            vq = m2 / divisor;
            want.variance_out = (vq > {16'd0, {VAR_W{1'b1}}}) ? '1 : vq[VAR_W-1:0];
         end
         expected_stats.push_back(want);
      endfunction

      function void compare(string what, logic [63:0] want, logic [63:0] got);
         if (got !== want) begin
            errors++;
            $display("%0t tb: %s mismatch, expected %0h, actual %0h",
                     $time, what, want, got);
         end
      endfunction

      // Match one delivered result against the oldest queued stats.
      function void match_stats(stats_item_type got);
         stats_item_type want;
         if (expected_stats.size() == 0) begin
            errors++;
            $display("%0t tb: result with none expected, expected none, actual count %0h",
                     $time, got.sample_count);
            return;
         end
         want = expected_stats.pop_front();
         compare("sample_count", want.sample_count, got.sample_count);
         compare("mean_value",   want.mean_value,   got.mean_value);
         compare("sum_sq_dev",   want.sum_sq_dev,   got.sum_sq_dev);
         compare("variance_out", want.variance_out, got.variance_out);
         compare("status",       want.status,       got.status);
      endfunction
   endclass

   logic clock;
   logic reset;

   rmv_req_if req_ch ();
   rmv_rsp_if rsp_ch ();

   running_mean_variance_core #(
      .COUNT_BITS (CNT_BITS),
      .FRAC_BITS  (FRAC)
   ) u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source)
   );

   welford_tracker_type tracker = new();

   // Idling knobs, changed by the stimulus as it moves through its phases.
   int sender_idle_pct    = 0;
   int receiver_stall_pct = 0;
   int hold_request       = 0;   // nonzero asks the receiver for a hold-off
   int random_done        = 0;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Safety net: a hung handshake ends the run here.
   initial begin
      #5_000_000;
      $display("tb: FAIL");
      $finish;
   end

   // Offer one sample; return at the edge that accepts it. Valid is lowered
   // only for an idle gap, so back-to-back items keep it high.
   task automatic offer_sample(input logic signed [SAMPLE_W-1:0] x, input logic rst);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.sample  <= x;
      req_ch.restart <= rst;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      tracker.fold_sample(x, rst);
   endtask

   // One statistics run: usually led by a restart, rarely broken by another.
   // Content is full-range noise, the extremes, or a cluster around a center.
   task automatic stats_run(input int len, input bit lead_restart);
      int                         style;
      int                         k;
      int                         v;
      logic signed [SAMPLE_W-1:0] center;
      logic signed [SAMPLE_W-1:0] x;
      logic                       rst;
      style  = $urandom_range(0, 3);
      center = SAMPLE_W'($urandom);
      for (k = 0; k < len; k++) begin
         case (style)
            0: begin
               x = SAMPLE_W'($urandom);
            end
            1: begin
               case ($urandom_range(0, 4))
                  0: x = 16'sh8000;
                  1: x = 16'sh7fff;
                  2: x = -16'sd1;
                  3: x = 16'sd0;
                  default: x = 16'sd1;
               endcase
            end
            default: begin
               v = int'(center) + int'($urandom_range(0, 4095)) - 2048;
               if (v > 32767) v = 32767;
               if (v < -32768) v = -32768;
               x = v[SAMPLE_W-1:0];
            end
         endcase
         rst = (k == 0) ? lead_restart : ($urandom_range(0, 99) == 0);
         offer_sample(x, rst);
         random_done++;
         // rotate the idling phase every 150 items
         case ((random_done / 150) % 4)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 61; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 61; end
            default: begin sender_idle_pct = 25; receiver_stall_pct = 25; end
         endcase
         // long receiver hold while the sender keeps pushing: fills the core
         if (random_done == PRESSURE_AT) hold_request = LONG_HOLD;
      end
   endtask

   // Receiver: check every delivered item, then pick ready for the next edge.
   initial begin
      int             hold_left;
      stats_item_type got;
      hold_left = 0;
      rsp_ch.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            got.sample_count = rsp_ch.sample_count;
            got.mean_value   = rsp_ch.mean_value;
            got.sum_sq_dev   = rsp_ch.sum_sq_dev;
            got.variance_out = rsp_ch.variance_out;
            got.status       = rsp_ch.status;
            tracker.match_stats(got);
         end
         if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
         end
         @(posedge clock);
      end
   end

   // Stimulus: reset, directed corners, random runs, drain, verdict.
   initial begin
      reset          <= 1'b1;
      req_ch.valid   <= 1'b0;
      req_ch.sample  <= '0;
      req_ch.restart <= 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // first sample straight out of reset, no restart: count starts at one
      offer_sample(16'sh8000, 1'b0);
      offer_sample(16'sh7fff, 1'b0);
      offer_sample(16'sh7fff, 1'b0);
      offer_sample(-16'sd1,   1'b0);
      offer_sample(16'sd0,    1'b0);
      offer_sample(16'sd1,    1'b0);
      // restart always reports a single sample
      offer_sample(16'sh7fff, 1'b1);
      offer_sample(16'sh8000, 1'b0);   // widest possible delta
      offer_sample(16'sh8000, 1'b1);
      offer_sample(16'sh8000, 1'b0);   // zero spread
      offer_sample(16'sh7fff, 1'b0);
      offer_sample(16'sh5555, 1'b1);
      offer_sample(16'shAAAA, 1'b0);
      offer_sample(16'sh7ffe, 1'b0);
      offer_sample(16'sd0,    1'b1);
      offer_sample(16'sd0,    1'b1);   // back-to-back restarts
      offer_sample(16'sd0,    1'b0);
      offer_sample(-16'sd2,   1'b0);

      // a short run, then a long one, both led by a restart
      stats_run(30, 1'b1);
      stats_run(LONG_RUN, 1'b1);
      while (random_done < RANDOM_ITEMS)
         stats_run($urandom_range(1, 24), $urandom_range(0, 9) != 0);

      req_ch.valid <= 1'b0;
      while (tracker.expected_stats.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (tracker.errors == 0)
         $display("tb: PASS");
      else
         $display("tb: FAIL");
      $finish;
   end

endmodule
